/* src/sample_hold_rate_reducer_unit_macros.svh */
// assertion macros shared by the rate reducer rtl
`ifndef SAMPLE_HOLD_RATE_REDUCER_UNIT_MACROS_SVH
`define SAMPLE_HOLD_RATE_REDUCER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SHRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SHRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/shrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrr_pkg
// shared types and constants of the sample-and-hold rate reducer
// ----------------------------------------------------------------------------
package shrr_pkg;

	// phase accumulator format, signed q3.30
	localparam int PHASE_FRAC = 30;
	localparam int PHASE_BITS = 34;
	localparam logic signed [PHASE_BITS-1:0] PHASE_ONE = 34'sh0_4000_0000;
	localparam logic signed [PHASE_BITS-1:0] WEIGHT_LIM = 34'sh0_7FFF_FFFF;

	// fixed field widths
	localparam int CHANNEL_W = 3;
	localparam int HZ_W = 24;
	localparam int RATE_W = 21;
	localparam int CFG_IDX_W = 2;
	localparam int QUOT_W = PHASE_FRAC + 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE = 2'd1;

	localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 21'd48000;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} shrr_state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} shrr_div_status_t;

endpackage

/* src/shrr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrr_div
// restoring divider for the phase step, one quotient bit per cycle
// ----------------------------------------------------------------------------
module shrr_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [shrr_pkg::HZ_W-1:0]           mag,
	input  logic [shrr_pkg::RATE_W-1:0]         divisor,
	output logic [shrr_pkg::QUOT_W-1:0]         quot,
	output shrr_pkg::shrr_div_status_t          status
);

	localparam int FRAC = shrr_pkg::PHASE_FRAC;
	localparam int RW = shrr_pkg::RATE_W;
	localparam int CNT_W = $clog2(FRAC + 1);

	logic [RW:0]          rem_q;
	logic [FRAC-1:0]      qbits_q;
	logic                 sat_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RW+1:0]        rem2;
	logic [RW+1:0]        trial;
	logic                 take;

	// shared subtract and compare
	assign rem2  = {rem_q, 1'b0};
	assign trial = rem2 - {1'b0, 1'b0, divisor};
	assign take  = rem2 >= {1'b0, 1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// a ratio of one or more clips to a full step at once
				if (mag >= {{(shrr_pkg::HZ_W-RW){1'b0}}, divisor}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(FRAC);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q   <= mag >= {{(shrr_pkg::HZ_W-RW){1'b0}}, divisor};
			rem_q   <= mag[RW:0];
			qbits_q <= '0;
		end else if (busy_q) begin
			rem_q   <= take ? trial[RW:0] : rem2[RW:0];
			qbits_q <= {qbits_q[FRAC-2:0], take};
		end
	end

	assign quot = sat_q ? {1'b1, {FRAC{1'b0}}} : {1'b0, qbits_q};
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

/* src/shrr_chan_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrr_chan_mem
// per-channel phase and held sample pair, with valid bits for reset values
// ----------------------------------------------------------------------------
module shrr_chan_mem #(
	parameter int NUM_CHANNELS = 8,
	parameter int SAMPLE_BITS = 24,
	parameter int CH_W = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_en,
	input  logic [CH_W-1:0]                       rd_addr,
	input  logic                                  wr_en,
	input  logic [CH_W-1:0]                       wr_addr,
	input  logic signed [shrr_pkg::PHASE_BITS-1:0] wr_phase,
	input  logic signed [SAMPLE_BITS-1:0]         wr_new,
	input  logic signed [SAMPLE_BITS-1:0]         wr_old,
	output logic signed [shrr_pkg::PHASE_BITS-1:0] rd_phase,
	output logic signed [SAMPLE_BITS-1:0]         rd_new,
	output logic signed [SAMPLE_BITS-1:0]         rd_old
);

	localparam int PB = shrr_pkg::PHASE_BITS;
	localparam int ENTRY_W = PB + 2 * SAMPLE_BITS;

	logic [ENTRY_W-1:0]      mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] valid_q;
	logic [ENTRY_W-1:0]      rd_data_q;
	logic                    rd_valid_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_phase, wr_new, wr_old};
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// never-written entries read as the reset values
	always_comb begin
		if (rd_valid_q) begin
			rd_phase = rd_data_q[ENTRY_W-1 -: PB];
			rd_new   = rd_data_q[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
			rd_old   = rd_data_q[SAMPLE_BITS-1:0];
		end else begin
			rd_phase = shrr_pkg::PHASE_ONE;
			rd_new   = '0;
			rd_old   = '0;
		end
	end

endmodule

/* src/shrr_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrr_blend
// linear blend of the held pair by a q.30 weight, rounded and saturated
// ----------------------------------------------------------------------------
module shrr_blend #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] held_new,
	input  logic signed [SAMPLE_BITS-1:0] held_old,
	input  logic signed [31:0]            weight,
	output logic signed [SAMPLE_BITS-1:0] blend
);

	localparam int S = SAMPLE_BITS;
	localparam int PW = S + 33;
	localparam int FRAC = shrr_pkg::PHASE_FRAC;
	localparam logic signed [S+3:0] SAT_HI = {5'b00000, {(S-1){1'b1}}};
	localparam logic signed [S+3:0] SAT_LO = {5'b11111, {(S-1){1'b0}}};
	localparam logic signed [PW-1:0] HALF = {{(PW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

	logic signed [S:0]    diff;
	logic signed [PW-1:0] diff_ext;
	logic signed [PW-1:0] weight_ext;
	logic signed [PW-1:0] prod_s1;
	logic signed [S-1:0]  old_s1;
	logic signed [PW-1:0] rounded;
	logic signed [S+3:0]  shifted;
	logic signed [S+3:0]  sum;

	assign diff       = {held_new[S-1], held_new} - {held_old[S-1], held_old};
	assign diff_ext   = {{(PW-S-1){diff[S]}}, diff};
	assign weight_ext = {{(PW-32){weight[31]}}, weight};

	// product register
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= diff_ext * weight_ext;
			old_s1  <= held_old;
		end
	end

	// round half up, floor shift, add base, saturate
	assign rounded = prod_s1 + HALF;
	assign shifted = {rounded[PW-1], rounded[PW-1:FRAC]};
	assign sum     = {{4{old_s1[S-1]}}, old_s1} + shifted;

	always_comb begin
		if (sum > SAT_HI) begin
			blend = SAT_HI[S-1:0];
		end else if (sum < SAT_LO) begin
			blend = SAT_LO[S-1:0];
		end else begin
			blend = sum[S-1:0];
		end
	end

endmodule

/* src/sample_hold_rate_reducer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_hold_rate_reducer_unit
// per-channel sample-and-hold rate reducer with optional linear blend
// ----------------------------------------------------------------------------
// channel   | handshake             | payload
// item      | item_valid/item_stall | channel, sample_in, hold_hz, restart
// result    | result_valid/...stall | sample_out
// cfg       | cfg_we                | cfg_index, cfg_data
//
// an item goes from acceptance through read and update, divide (quotient bits,
// then the done flag), multiply and output load; a saturated step skips the
// quotient bits, a channel out of range skips divide and multiply. item_stall
// stays high until the result is loaded into the output register, which then
// waits on result_stall alone; the next item can be taken in the cycle after.
// reset is asynchronous; no clearing pass is needed, valid bits serve.
// ----------------------------------------------------------------------------
`include "sample_hold_rate_reducer_unit_macros.svh"

module sample_hold_rate_reducer_unit #(
	parameter int NUM_CHANNELS = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [shrr_pkg::CHANNEL_W-1:0]       channel,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	input  logic signed [shrr_pkg::HZ_W-1:0]     hold_hz,
	input  logic                                 restart,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [SAMPLE_BITS-1:0]        sample_out,
	input  logic                                 cfg_we,
	input  logic [shrr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [shrr_pkg::RATE_W-1:0]          cfg_data
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PB = shrr_pkg::PHASE_BITS;
	localparam int HW = shrr_pkg::HZ_W;
	localparam int RW = shrr_pkg::RATE_W;
	localparam int QW = shrr_pkg::QUOT_W;

	shrr_pkg::shrr_state_t      state_q, state_d;
	shrr_pkg::shrr_div_status_t div_status;

	logic [RW-1:0]                sample_rate_q;
	logic                         interpolate_q;

	logic [CH_W-1:0]              ch_q;
	logic                         oor_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic                         fwd_q;
	logic [HW-1:0]                mag_q;
	logic                         restart_q;

	logic signed [PB-1:0]         phase_q;
	logic signed [SAMPLE_BITS-1:0] new_q;
	logic signed [SAMPLE_BITS-1:0] old_q;

	logic                         result_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	logic                         accept;
	logic                         rd_en;
	logic                         div_start;
	logic                         mul_en;
	logic                         out_load;

	logic signed [PB-1:0]         rd_phase;
	logic signed [SAMPLE_BITS-1:0] rd_new;
	logic signed [SAMPLE_BITS-1:0] rd_old;
	logic                         take_new;
	logic signed [PB-1:0]         phase_upd;

	logic [RW-1:0]                divisor;
	logic [QW-1:0]                quot;
	logic signed [PB-1:0]         step;
	logic signed [PB-1:0]         weight_full;
	logic signed [31:0]           weight;
	logic signed [SAMPLE_BITS-1:0] blend;

	assign accept = item_valid && !item_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= shrr_pkg::SAMPLE_RATE_RST;
			interpolate_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				shrr_pkg::CFG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				shrr_pkg::CFG_INTERPOLATE: interpolate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shrr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and strobes
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		rd_en      = 1'b0;
		div_start  = 1'b0;
		mul_en     = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			shrr_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				rd_en      = item_valid;
				if (item_valid) begin
					state_d = shrr_pkg::ST_READ;
				end
			end
			shrr_pkg::ST_READ: begin
				if (oor_q) begin
					state_d = shrr_pkg::ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = shrr_pkg::ST_DIV;
				end
			end
			shrr_pkg::ST_DIV: begin
				if (div_status.done) begin
					state_d = shrr_pkg::ST_MUL;
				end
			end
			shrr_pkg::ST_MUL: begin
				mul_en  = 1'b1;
				state_d = shrr_pkg::ST_OUT;
			end
			shrr_pkg::ST_OUT: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = shrr_pkg::ST_IDLE;
				end
			end
			default: state_d = shrr_pkg::ST_IDLE;
		endcase
	end

	// capture of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= CH_W'(channel);
			oor_q     <= 32'(channel) >= NUM_CHANNELS;
			smp_q     <= sample_in;
			fwd_q     <= !hold_hz[HW-1];
			mag_q     <= hold_hz[HW-1] ? (~hold_hz + 1'b1) : hold_hz;
			restart_q <= restart;
		end
	end

	// wrap or restart test on the stored phase
	always_comb begin
		take_new  = 1'b1;
		phase_upd = rd_phase;
		priority if (restart_q) begin
			phase_upd = '0;
		end else if (fwd_q && rd_phase >= shrr_pkg::PHASE_ONE) begin
			phase_upd = rd_phase - shrr_pkg::PHASE_ONE;
		end else if (!fwd_q && rd_phase <= 0) begin
			phase_upd = rd_phase + shrr_pkg::PHASE_ONE;
		end else begin
			take_new = 1'b0;
		end
	end

	// working copy of the channel state
	always_ff @(posedge clk) begin
		if (state_q == shrr_pkg::ST_READ) begin
			phase_q <= phase_upd;
			new_q   <= take_new ? smp_q : rd_new;
			old_q   <= take_new ? rd_new : rd_old;
		end
	end

	shrr_chan_mem #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.CH_W         (CH_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (CH_W'(channel)),
		.wr_en    (mul_en),
		.wr_addr  (ch_q),
		.wr_phase (phase_q + step),
		.wr_new   (new_q),
		.wr_old   (old_q),
		.rd_phase (rd_phase),
		.rd_new   (rd_new),
		.rd_old   (rd_old)
	);

	// step = |hz| / rate in q.30, a zero rate divides by one
	assign divisor = (sample_rate_q == '0) ? RW'(1) : sample_rate_q;

	shrr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.mag     (mag_q),
		.divisor (divisor),
		.quot    (quot),
		.status  (div_status)
	);

	assign step = fwd_q ? {{(PB-QW){1'b0}}, quot} : -{{(PB-QW){1'b0}}, quot};

	// blend weight, phase forward and one minus phase in reverse
	always_comb begin
		weight_full = fwd_q ? phase_q : (shrr_pkg::PHASE_ONE - phase_q);
		if (weight_full > shrr_pkg::WEIGHT_LIM) begin
			weight = shrr_pkg::WEIGHT_LIM[31:0];
		end else if (weight_full < -shrr_pkg::WEIGHT_LIM) begin
			weight = -shrr_pkg::WEIGHT_LIM[31:0];
		end else begin
			weight = weight_full[31:0];
		end
	end

	shrr_blend #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_blend (
		.clk      (clk),
		.en       (mul_en),
		.held_new (new_q),
		.held_old (old_q),
		.weight   (weight),
		.blend    (blend)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (oor_q) begin
				sample_out_q <= '0;
			end else if (interpolate_q) begin
				sample_out_q <= blend;
			end else begin
				sample_out_q <= new_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign sample_out   = sample_out_q;

	// sequencer checks
	`SHRR_ASSERT_NEXT(a_accept_then_busy, clk, arst_n, accept, item_stall && state_q == shrr_pkg::ST_READ, "accepted transaction did not start a read")
	`SHRR_ASSERT_NOW(a_done_in_div, clk, arst_n, div_status.done, state_q == shrr_pkg::ST_DIV, "divider finished outside the divide state")
	`SHRR_ASSERT_NOW(a_div_runs, clk, arst_n, state_q == shrr_pkg::ST_DIV, div_status.busy || div_status.done, "divide state with idle divider")
	`SHRR_ASSERT_NOW(a_no_oor_write, clk, arst_n, mul_en, !oor_q, "state write for a channel out of range")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the sample-and-hold rate reducer against a cycle-free predictor:
// a short directed run over field extremes, saturating blends and a zero
// sample rate, then random per-channel frequency runs under several
// register settings, with random gaps on both channels, two long result
// hold-offs and a drain before every register change
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_CH = 8;
	localparam int SAMPLE_W = 24;
	localparam int RANDOM_PHASES = 9;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int DRAIN_CYCLES = 48;
	localparam int LONG_HOLD = 400;
	localparam int CYCLE_LIMIT = 1000000;

	typedef logic signed [shrr_pkg::PHASE_BITS-1:0] phase_t;
	typedef logic signed [shrr_pkg::HZ_W-1:0] hz_t;
	typedef logic [shrr_pkg::RATE_W-1:0] rate_t;

	typedef struct packed {
		logic [shrr_pkg::CHANNEL_W-1:0] channel;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [shrr_pkg::HZ_W-1:0] hz;
		logic restart;
	} reducer_item_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [shrr_pkg::CHANNEL_W-1:0] channel;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic signed [shrr_pkg::HZ_W-1:0] hold_hz;
	logic restart;
	logic result_valid;
	logic result_stall;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic cfg_we;
	logic [shrr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [shrr_pkg::RATE_W-1:0] cfg_data;

	// predictor state and register copies
	phase_t chan_phase [NUM_CH];
	logic signed [SAMPLE_W-1:0] chan_held_new [NUM_CH];
	logic signed [SAMPLE_W-1:0] chan_held_old [NUM_CH];
	rate_t rate_cfg;
	logic blend_cfg;

	// stimulus plan per channel
	hz_t chan_hz_plan [NUM_CH];

	reducer_item_t pending_items [$];
	reducer_item_t offered_item;
	logic signed [SAMPLE_W-1:0] expected_samples [$];
	logic signed [SAMPLE_W-1:0] want_sample;
	bit item_offered;
	int unsigned tx_gap_left;
	int unsigned tx_calm_left;
	int unsigned rx_wait_left;
	int unsigned rx_calm_left;
	int unsigned hold_asks;
	int unsigned hold_served;
	int unsigned mismatches;
	int unsigned cycle_count;

	rate_t phase_rate [RANDOM_PHASES] =
		'{21'd48000, 21'd48000, 21'd44100, 21'd1, 21'd1048576, 21'd2097151, 21'd0,
		  21'd96000, 21'd8000};
	logic phase_blend [RANDOM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

	sample_hold_rate_reducer_unit #(
		.NUM_CHANNELS(NUM_CH),
		.SAMPLE_BITS(SAMPLE_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.channel(channel),
		.sample_in(sample_in),
		.hold_hz(hold_hz),
		.restart(restart),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sample_out(sample_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// next held or blended sample of one transaction, updates channel state
	function automatic logic signed [SAMPLE_W-1:0] held_sample_predict(input reducer_item_t it);
		logic fwd;
		int unsigned ch;
		longint unit, lim, hi, lo, divisor, mag, quot, step, phase, weight, diff, outv;
		fwd = (it.hz[shrr_pkg::HZ_W-1] == 1'b0);
		ch = 32'(it.channel);
		unit = longint'(shrr_pkg::PHASE_ONE);
		lim = longint'(shrr_pkg::WEIGHT_LIM);
		hi = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		divisor = (rate_cfg == '0) ? 64'sd1 : longint'(rate_cfg);
		mag = longint'($signed(it.hz));
		if (!fwd)
			mag = -mag;
		quot = (mag <<< shrr_pkg::PHASE_FRAC) / divisor;
		if (quot > unit)
			quot = unit;
		step = fwd ? quot : -quot;
		phase = longint'(chan_phase[ch]);
		// capture a new sample on restart or on a phase crossing
		if (it.restart || (fwd && phase >= unit) || (!fwd && phase <= 0)) begin
			if (it.restart)
				phase = 0;
			else if (fwd)
				phase = phase - unit;
			else
				phase = phase + unit;
			chan_held_old[ch] = chan_held_new[ch];
			chan_held_new[ch] = it.sample;
		end
		// blend by phase, rounded half up, then saturated
		if (blend_cfg) begin
			weight = fwd ? phase : unit - phase;
			if (weight > lim)
				weight = lim;
			if (weight < -lim)
				weight = -lim;
			diff = longint'(chan_held_new[ch]) - longint'(chan_held_old[ch]);
			outv = longint'(chan_held_old[ch]) +
				((diff * weight + (64'sd1 <<< (shrr_pkg::PHASE_FRAC - 1))) >>>
				shrr_pkg::PHASE_FRAC);
			if (outv > hi)
				outv = hi;
			if (outv < lo)
				outv = lo;
		end else begin
			outv = longint'(chan_held_new[ch]);
		end
		// phase wraps within its own width
		chan_phase[ch] = phase_t'(phase + step);
		return outv[SAMPLE_W-1:0];
	endfunction

	// per-transaction wait, with occasional runs of no waiting at all
	function automatic int unsigned draw_wait(inout int unsigned calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm_left = $urandom_range(16, 64);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	function automatic reducer_item_t make_item(input int unsigned ch, input int smp,
			input int hz, input bit rst);
		reducer_item_t it;
		it.channel = ch[shrr_pkg::CHANNEL_W-1:0];
		it.sample = smp[SAMPLE_W-1:0];
		it.hz = hz[shrr_pkg::HZ_W-1:0];
		it.restart = rst;
		return it;
	endfunction

	// random transaction: channels keep a frequency for a while, some noise
	function automatic reducer_item_t draw_item();
		reducer_item_t it;
		int unsigned ch, cap, mag;
		hz_t hz_v;
		ch = $urandom_range(0, NUM_CH - 1);
		if ($urandom_range(0, 19) == 0) begin
			cap = (rate_cfg == '0) ? 32'd8 : 32'(rate_cfg);
			if (cap > 4194303)
				cap = 4194303;
			case ($urandom_range(0, 3))
				0, 1: mag = $urandom_range(0, cap);
				2: mag = $urandom_range(0, 2 * cap);
				default: mag = $urandom_range(0, 8388607);
			endcase
			hz_v = mag[shrr_pkg::HZ_W-1:0];
			if ($urandom_range(0, 1) == 1)
				hz_v = -hz_v;
			chan_hz_plan[ch] = hz_v;
		end
		it.channel = ch[shrr_pkg::CHANNEL_W-1:0];
		it.sample = SAMPLE_W'($urandom);
		it.hz = chan_hz_plan[ch];
		it.restart = ($urandom_range(0, 15) == 0);
		if ($urandom_range(0, 9) == 0)
			it.hz = hz_t'($urandom);
		return it;
	endfunction

	task automatic write_reg(input logic [shrr_pkg::CFG_IDX_W-1:0] idx, input rate_t data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == shrr_pkg::CFG_SAMPLE_RATE)
			rate_cfg = data;
		else if (idx == shrr_pkg::CFG_INTERPOLATE)
			blend_cfg = data[0];
	endtask

	// wait until every queued transaction has its result, then let the block settle
	task automatic wait_drained();
		while (pending_items.size() != 0 || item_offered || expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("sample_hold_rate_reducer_unit: mismatch");
		$finish;
	end

	// driver: offers queued transactions with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				expected_samples.push_back(held_sample_predict(offered_item));
				item_offered = 1'b0;
				tx_gap_left = draw_wait(tx_calm_left);
			end
			if (!item_offered) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					offered_item = pending_items.pop_front();
					item_offered = 1'b1;
					item_valid <= 1'b1;
					channel <= offered_item.channel;
					sample_in <= offered_item.sample;
					hold_hz <= offered_item.hz;
					restart <= offered_item.restart;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction, draws its own stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: result with none expected: expected none actual %0d",
						$time, sample_out);
					mismatches++;
				end else begin
					want_sample = expected_samples.pop_front();
					if (sample_out !== want_sample) begin
						$display("%0t: sample_out wrong: expected %0d actual %0d",
							$time, want_sample, sample_out);
						mismatches++;
					end
				end
				rx_wait_left = draw_wait(rx_calm_left);
			end
			// long hold-off so the block backs up into its input
			if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				rx_wait_left = LONG_HOLD;
			end
			result_stall <= (rx_wait_left > 0);
			if (rx_wait_left > 0)
				rx_wait_left--;
		end
	end

	// stimulus and end of run
	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		channel = '0;
		sample_in = '0;
		hold_hz = '0;
		restart = 1'b0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = shrr_pkg::CFG_SAMPLE_RATE;
		cfg_data = '0;
		item_offered = 1'b0;
		tx_gap_left = 0;
		tx_calm_left = 0;
		rx_wait_left = 0;
		rx_calm_left = 0;
		hold_asks = 0;
		hold_served = 0;
		mismatches = 0;
		rate_cfg = shrr_pkg::SAMPLE_RATE_RST;
		blend_cfg = 1'b0;
		for (int c = 0; c < NUM_CH; c++) begin
			chan_phase[c] = shrr_pkg::PHASE_ONE;
			chan_held_new[c] = '0;
			chan_held_old[c] = '0;
			chan_hz_plan[c] = 24'sd1000;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// register values after reset: field extremes and every channel
		pending_items.push_back(make_item(0, 8388607, 8388607, 1'b0));
		pending_items.push_back(make_item(1, -8388608, -8388608, 1'b0));
		pending_items.push_back(make_item(1, 1234, -8388608, 1'b0));
		pending_items.push_back(make_item(2, 5, 0, 1'b1));
		pending_items.push_back(make_item(7, 0, 1, 1'b0));
		for (int c = 0; c < NUM_CH; c++)
			pending_items.push_back(make_item(c, (c % 2) ? -8388608 : 8388607, 48000, 1'b0));
		wait_drained();

		// full steps with blending: extrapolation saturates low, then high
		write_reg(shrr_pkg::CFG_SAMPLE_RATE, 21'd1);
		write_reg(shrr_pkg::CFG_INTERPOLATE, 21'd1);
		pending_items.push_back(make_item(5, -8388608, -1, 1'b1));
		pending_items.push_back(make_item(5, 8388607, -1, 1'b1));
		pending_items.push_back(make_item(5, 0, 0, 1'b0));
		pending_items.push_back(make_item(6, 8388607, -1, 1'b1));
		pending_items.push_back(make_item(6, -8388608, -1, 1'b1));
		pending_items.push_back(make_item(6, 0, 0, 1'b0));
		wait_drained();

		// zero sample rate acts as a divisor of one
		write_reg(shrr_pkg::CFG_SAMPLE_RATE, 21'd0);
		pending_items.push_back(make_item(3, 100, 7, 1'b0));
		pending_items.push_back(make_item(3, -200, 7, 1'b0));
		pending_items.push_back(make_item(3, 300, 7, 1'b0));
		pending_items.push_back(make_item(3, -400, -3, 1'b0));
		pending_items.push_back(make_item(3, 500, -3, 1'b0));
		wait_drained();

		// random runs, one register setting each
		phase_rate[7] = rate_t'($urandom_range(1, 1048576));
		phase_blend[7] = 1'($urandom_range(0, 1));
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(shrr_pkg::CFG_SAMPLE_RATE, phase_rate[p]);
			write_reg(shrr_pkg::CFG_INTERPOLATE, {20'd0, phase_blend[p]});
			if (p == 2 || p == 5)
				hold_asks++;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				pending_items.push_back(draw_item());
			wait_drained();
		end

		if (mismatches == 0)
			$display("sample_hold_rate_reducer_unit: match");
		else
			$display("sample_hold_rate_reducer_unit: mismatch");
		$finish;
	end

endmodule
